### hw/rtl/sqf_pkg.sv
// Shared types and character constants for the straight-to-curly quote filter.
package sqf_pkg;

  localparam int CP_BITS  = 21;
  localparam int OUT_SPACE_BITS = 16;
  localparam int IN_TDATA_BITS  = 24;
  localparam int OUT_TDATA_BITS = 40;

  localparam logic [CP_BITS-1:0] CH_LF    = 21'h00000A;
  localparam logic [CP_BITS-1:0] CH_CR    = 21'h00000D;
  localparam logic [CP_BITS-1:0] CH_SP    = 21'h000020;
  localparam logic [CP_BITS-1:0] CH_DQ    = 21'h000022;
  localparam logic [CP_BITS-1:0] CH_OPEN  = 21'h00201C;
  localparam logic [CP_BITS-1:0] CH_CLOSE = 21'h00201D;

  localparam logic REG_OLD_STYLE_MODE = 1'b0;

  typedef struct packed {
    logic                      last;
    logic                      warn_open_before_space;
    logic                      warn_close_after_space;
    logic [OUT_SPACE_BITS-1:0] spaces_before;
    logic [CP_BITS-1:0]        code_point;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } emit_t;

endpackage

### hw/rtl/sqf_core.sv
// Per-character quote and whitespace state with result generation.
module sqf_core #(
  parameter int SPACE_COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [sqf_pkg::CP_BITS-1:0] code_point,
  input  logic                        old_style_mode,
  output sqf_pkg::emit_t              emit
);

  logic                        inside_quote, inside_quote_next;
  logic [SPACE_COUNT_BITS-1:0] spaces_before_cr, spaces_before_cr_next;
  logic                        cr_held, cr_held_next;
  logic [SPACE_COUNT_BITS-1:0] spaces_held, spaces_held_next;
  logic                        line_has_text, line_has_text_next;
  logic                        open_check_pending, open_check_pending_next;
  logic                        open_warn_pending, open_warn_pending_next;

  logic [sqf_pkg::OUT_SPACE_BITS-1:0] sh_sat, cr_sat;
  logic                               sh_nz;

  assign sh_nz = (spaces_held != '0);

  if (SPACE_COUNT_BITS > sqf_pkg::OUT_SPACE_BITS) begin : g_sat
    assign sh_sat = (|spaces_held[SPACE_COUNT_BITS-1:sqf_pkg::OUT_SPACE_BITS]) ?
                    '1 : spaces_held[sqf_pkg::OUT_SPACE_BITS-1:0];
    assign cr_sat = (|spaces_before_cr[SPACE_COUNT_BITS-1:sqf_pkg::OUT_SPACE_BITS]) ?
                    '1 : spaces_before_cr[sqf_pkg::OUT_SPACE_BITS-1:0];
  end else begin : g_ext
    assign sh_sat = sqf_pkg::OUT_SPACE_BITS'(spaces_held);
    assign cr_sat = sqf_pkg::OUT_SPACE_BITS'(spaces_before_cr);
  end

  logic                        is_lf, is_cr, is_sp, is_dq;
  logic                        ocp, owp, prev_space;
  logic [sqf_pkg::CP_BITS-1:0] glyph;
  logic                        wclose;

  assign is_lf = (code_point == sqf_pkg::CH_LF);
  assign is_cr = (code_point == sqf_pkg::CH_CR);
  assign is_sp = (code_point == sqf_pkg::CH_SP);
  assign is_dq = (code_point == sqf_pkg::CH_DQ);

  always_comb begin
    // resolve look-ahead of a preceding open quote
    ocp = open_check_pending;
    owp = open_warn_pending;
    if (open_check_pending) begin
      if (cr_held) begin
        if (is_lf && !sh_nz) owp = 1'b1;
        ocp = 1'b0;
      end else if (!is_cr) begin
        if (is_sp || is_lf) owp = 1'b1;
        ocp = 1'b0;
      end
    end

    prev_space = sh_nz || (!cr_held && !line_has_text);
    glyph      = code_point;
    wclose     = 1'b0;
    if (is_dq) begin
      glyph  = inside_quote ? sqf_pkg::CH_CLOSE : sqf_pkg::CH_OPEN;
      wclose = inside_quote && prev_space;
    end

    emit = '0;
    emit.first.warn_open_before_space = owp;
    emit.first.code_point    = sqf_pkg::CH_CR;
    emit.first.spaces_before = cr_sat;

    inside_quote_next       = inside_quote;
    spaces_before_cr_next   = spaces_before_cr;
    cr_held_next            = cr_held;
    spaces_held_next        = spaces_held;
    line_has_text_next      = line_has_text;
    open_check_pending_next = ocp;

    priority if (is_lf) begin
      if (cr_held && sh_nz) begin
        emit.count = 2'd2;
        emit.second.code_point = sqf_pkg::CH_LF;
        emit.second.last       = 1'b1;
      end else begin
        emit.count = 2'd1;
        emit.first.code_point    = sqf_pkg::CH_LF;
        emit.first.spaces_before = '0;
        emit.first.last          = 1'b1;
      end
      if (!(line_has_text || (cr_held && sh_nz)) || old_style_mode)
        inside_quote_next = 1'b0;
      spaces_held_next        = '0;
      spaces_before_cr_next   = '0;
      cr_held_next            = 1'b0;
      line_has_text_next      = 1'b0;
      open_check_pending_next = 1'b0;
    end else if (is_sp) begin
      if (spaces_held != '1)
        spaces_held_next = SPACE_COUNT_BITS'(spaces_held + 1'b1);
    end else if (is_cr) begin
      if (cr_held) begin
        emit.count = 2'd1;
        emit.first.last    = 1'b1;
        line_has_text_next = 1'b1;
      end
      cr_held_next          = 1'b1;
      spaces_before_cr_next = spaces_held;
      spaces_held_next      = '0;
    end else begin
      if (is_dq) inside_quote_next = !inside_quote;
      if (cr_held) begin
        emit.count = 2'd2;
        emit.second.code_point             = glyph;
        emit.second.spaces_before          = sh_sat;
        emit.second.warn_close_after_space = wclose;
        emit.second.last                   = 1'b1;
      end else begin
        emit.count = 2'd1;
        emit.first.code_point             = glyph;
        emit.first.spaces_before          = sh_sat;
        emit.first.warn_close_after_space = wclose;
        emit.first.last                   = 1'b1;
      end
      cr_held_next          = 1'b0;
      spaces_before_cr_next = '0;
      spaces_held_next      = '0;
      line_has_text_next    = 1'b1;
      if (is_dq && !inside_quote) open_check_pending_next = 1'b1;
    end

    open_warn_pending_next = (emit.count != 2'd0) ? 1'b0 : owp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quote       <= 1'b0;
      spaces_before_cr   <= '0;
      cr_held            <= 1'b0;
      spaces_held        <= '0;
      line_has_text      <= 1'b0;
      open_check_pending <= 1'b0;
      open_warn_pending  <= 1'b0;
    end else if (take) begin
      inside_quote       <= inside_quote_next;
      spaces_before_cr   <= spaces_before_cr_next;
      cr_held            <= cr_held_next;
      spaces_held        <= spaces_held_next;
      line_has_text      <= line_has_text_next;
      open_check_pending <= open_check_pending_next;
      open_warn_pending  <= open_warn_pending_next;
    end
  end

endmodule

### hw/rtl/sqf_outq.sv
// Four-entry result buffer taking up to two results per cycle.
module sqf_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sqf_pkg::emit_t   emit,
  output logic             room,
  output logic             valid,
  input  logic             take,
  output sqf_pkg::result_t head
);

  sqf_pkg::result_t mem [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;
  logic [1:0] nwr;

  assign nwr   = wr ? emit.count : 2'd0;
  assign room  = (count <= 3'd2);
  assign valid = (count != 3'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (nwr != 2'd0) mem[wptr] <= emit.first;
    if (nwr == 2'd2) mem[2'(wptr + 2'd1)] <= emit.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= 2'(wptr + nwr);
      rptr  <= 2'(rptr + {1'b0, take});
      count <= 3'(count + {1'b0, nwr} - {2'b00, take});
    end
  end

endmodule

### hw/rtl/straight_to_curly_quote_filter_unit.sv
// Top level: stream ports, config register, filter core and result buffer.
// An accepted request's results are registered in the buffer behind those held.
// Throughput: one request per cycle; a request yields zero, one or two results,
// and the four-entry buffer drains one result per cycle while m_tready is high.
// Input is ready while the buffer has room for two results.
// Reset (rst, synchronous) clears quote/space state, the buffer and the mode bit.
module straight_to_curly_quote_filter_unit #(
  parameter int SPACE_COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sqf_pkg::IN_TDATA_BITS-1:0]  s_tdata,  // [20:0] code_point
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [20:0] out_code_point, [36:21] spaces_before, [37] warn_close_after_space,
  // [38] warn_open_before_space
  output logic [sqf_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  output logic                               m_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic             old_style_mode;
  logic             take;
  sqf_pkg::emit_t   emit;
  sqf_pkg::result_t head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sqf_pkg::REG_OLD_STYLE_MODE) ? {31'd0, old_style_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      old_style_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == sqf_pkg::REG_OLD_STYLE_MODE) begin
      old_style_mode <= pwdata[0];
    end
  end

  assign take = s_tvalid && s_tready;

  sqf_core #(.SPACE_COUNT_BITS(SPACE_COUNT_BITS)) u_core (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .code_point     (s_tdata[sqf_pkg::CP_BITS-1:0]),
    .old_style_mode (old_style_mode),
    .emit           (emit)
  );

  sqf_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .wr    (take),
    .emit  (emit),
    .room  (s_tready),
    .valid (m_tvalid),
    .take  (m_tvalid && m_tready),
    .head  (head)
  );

  assign m_tdata = {1'b0, head.warn_open_before_space, head.warn_close_after_space,
                    head.spaces_before, head.code_point};
  assign m_tlast = head.last;

endmodule

### bench/straight_to_curly_quote_filter_unit_tb.sv
// Self-checking bench for the straight-to-curly quote filter: directed table, then random text.
module straight_to_curly_quote_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CP_W           = sqf_pkg::CP_BITS;
  localparam int          IN_W           = sqf_pkg::IN_TDATA_BITS;
  localparam int          OUT_W          = sqf_pkg::OUT_TDATA_BITS;
  localparam int          RAND_PER_PHASE = 480;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          SPACE_RUN      = 5;
  localparam logic [15:0] SPACE_SAT      = 16'hFFFF;
  localparam logic [2:0]  MODE_ADDR      = 3'(4 * int'(sqf_pkg::REG_OLD_STYLE_MODE));

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  straight_to_curly_quote_filter_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  typedef struct {
    logic [CP_W-1:0]  cp;
    int               reps;
    bit               typed;
    sqf_pkg::result_t res;
  } quote_row_t;

  quote_row_t       directed_rows[$];
  logic [CP_W-1:0]  char_script[$];
  sqf_pkg::result_t chars_due[$];
  sqf_pkg::result_t step_out[2];
  int               step_count;
  int               mismatch_count = 0;
  bit               steady = 1'b0;
  bit               hold_off_req = 1'b0;

  // filter state mirror
  logic        clear_each_line = 1'b0;
  logic        in_quote = 1'b0;
  logic        cr_pending = 1'b0;
  logic        line_text = 1'b0;
  logic        open_look = 1'b0;
  logic        open_warn = 1'b0;
  logic [15:0] sp_held = '0;
  logic [15:0] sp_before_cr = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic sqf_pkg::result_t one_result(logic [CP_W-1:0] cp, logic [15:0] sp,
                                                  logic wc, logic wo);
    sqf_pkg::result_t r;
    r.code_point             = cp;
    r.spaces_before          = sp;
    r.warn_close_after_space = wc;
    r.warn_open_before_space = wo;
    r.last                   = 1'b1;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CP_W-1:0] pick_noise();
    case ($urandom_range(0, 2))
      0: return CP_W'($urandom);
      1: return CP_W'($urandom_range(0, 127));
      default: return CP_W'($urandom_range(32'h80, 32'h10FFFF));
    endcase
  endfunction

  task automatic push_word();
    repeat ($urandom_range(1, 6))
      char_script.push_back(CP_W'($urandom_range(32'h61, 32'h7A)));
  endtask

  task automatic add_row(logic [CP_W-1:0] cp, int reps, bit typed, sqf_pkg::result_t res);
    quote_row_t row;
    row.cp    = cp;
    row.reps  = reps;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endtask

  task automatic add_snippet();
    case ($urandom_range(0, 9))
      0, 1, 2: push_word();
      3: repeat ($urandom_range(1, 3)) char_script.push_back(sqf_pkg::CH_SP);
      4: begin
        char_script.push_back(sqf_pkg::CH_DQ);
        if ($urandom_range(0, 3) == 0) char_script.push_back(sqf_pkg::CH_SP);
        push_word();
        if ($urandom_range(0, 3) == 0) char_script.push_back(sqf_pkg::CH_SP);
        char_script.push_back(sqf_pkg::CH_DQ);
      end
      5, 6: begin
        repeat ($urandom_range(0, 3)) char_script.push_back(sqf_pkg::CH_SP);
        if ($urandom_range(0, 2) == 0) char_script.push_back(sqf_pkg::CH_CR);
        if ($urandom_range(0, 3) == 0) char_script.push_back(sqf_pkg::CH_SP);
        char_script.push_back(sqf_pkg::CH_LF);
      end
      7: char_script.push_back(sqf_pkg::CH_DQ);
      8: begin
        char_script.push_back(sqf_pkg::CH_CR);
        char_script.push_back(pick_noise());
      end
      default: char_script.push_back(pick_noise());
    endcase
  endtask

  task automatic emit_char(logic [CP_W-1:0] cp, logic [15:0] sp, logic wc);
    step_out[step_count] = one_result(cp, sp, wc, open_warn);
    step_out[step_count].last = 1'b0;
    open_warn = 1'b0;
    step_count++;
  endtask

  task automatic predict_curly_quotes(logic [CP_W-1:0] c);
    logic            prev_space;
    logic [CP_W-1:0] out_cp;
    logic            wc;
    logic            opened;
    step_count = 0;
    if (open_look) begin
      if (cr_pending) begin
        if (c == sqf_pkg::CH_LF && sp_held == 0) open_warn = 1'b1;
        open_look = 1'b0;
      end else if (c != sqf_pkg::CH_CR) begin
        if (c == sqf_pkg::CH_SP || c == sqf_pkg::CH_LF) open_warn = 1'b1;
        open_look = 1'b0;
      end
    end
    if (c == sqf_pkg::CH_LF) begin
      if (cr_pending && sp_held != 0) begin
        emit_char(sqf_pkg::CH_CR, sp_before_cr, 1'b0);
        line_text = 1'b1;
      end
      emit_char(sqf_pkg::CH_LF, '0, 1'b0);
      if (!line_text || clear_each_line) in_quote = 1'b0;
      sp_held      = '0;
      sp_before_cr = '0;
      cr_pending   = 1'b0;
      line_text    = 1'b0;
      open_look    = 1'b0;
    end else if (c == sqf_pkg::CH_SP) begin
      if (sp_held != SPACE_SAT) sp_held++;
    end else if (c == sqf_pkg::CH_CR) begin
      if (cr_pending) begin
        emit_char(sqf_pkg::CH_CR, sp_before_cr, 1'b0);
        line_text = 1'b1;
      end
      cr_pending   = 1'b1;
      sp_before_cr = sp_held;
      sp_held      = '0;
    end else begin
      prev_space = (sp_held != 0) || (!cr_pending && !line_text);
      out_cp     = c;
      wc         = 1'b0;
      opened     = 1'b0;
      if (c == sqf_pkg::CH_DQ) begin
        if (in_quote) begin
          out_cp   = sqf_pkg::CH_CLOSE;
          wc       = prev_space;
          in_quote = 1'b0;
        end else begin
          out_cp   = sqf_pkg::CH_OPEN;
          in_quote = 1'b1;
          opened   = 1'b1;
        end
      end
      if (cr_pending) emit_char(sqf_pkg::CH_CR, sp_before_cr, 1'b0);
      emit_char(out_cp, sp_held, wc);
      cr_pending   = 1'b0;
      sp_before_cr = '0;
      sp_held      = '0;
      line_text    = 1'b1;
      if (opened) open_look = 1'b1;
    end
    if (step_count > 0) step_out[step_count-1].last = 1'b1;
  endtask

  task automatic send_code(logic [CP_W-1:0] cp, bit typed, sqf_pkg::result_t res);
    int gap;
    s_tdata  <= IN_W'(cp);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_curly_quotes(cp);
    if (typed) begin
      step_count  = 1;
      step_out[0] = res;
    end
    for (int i = 0; i < step_count; i++) chars_due.push_back(step_out[i]);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= {31'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    clear_each_line = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, value}) begin
      mismatch_count++;
      $display("%0t: mode readback expected %0h actual %0h", $time, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    sqf_pkg::result_t got;
    sqf_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = sqf_pkg::result_t'({m_tlast, m_tdata[OUT_W-2:0]});
      if (chars_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result expected none actual %0h", $time, got);
      end else begin
        want = chars_due.pop_front();
        check_field("code_point", 32'(want.code_point), 32'(got.code_point));
        check_field("spaces_before", 32'(want.spaces_before), 32'(got.spaces_before));
        check_field("warn_close_after_space", 32'(want.warn_close_after_space),
                    32'(got.warn_close_after_space));
        check_field("warn_open_before_space", 32'(want.warn_open_before_space),
                    32'(got.warn_open_before_space));
        check_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(1'b0);

    add_row(sqf_pkg::CH_DQ, 1, 1'b1, one_result(sqf_pkg::CH_OPEN, 16'd0, 1'b0, 1'b0));
    add_row(sqf_pkg::CH_SP, 1, 1'b0, '0);
    add_row(21'h61, 1, 1'b1, one_result(21'h61, 16'd1, 1'b0, 1'b1));
    add_row(sqf_pkg::CH_DQ, 1, 1'b1, one_result(sqf_pkg::CH_CLOSE, 16'd0, 1'b0, 1'b0));
    add_row(sqf_pkg::CH_SP, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_DQ, 1, 1'b1, one_result(sqf_pkg::CH_OPEN, 16'd1, 1'b0, 1'b0));
    add_row(sqf_pkg::CH_LF, 1, 1'b1, one_result(sqf_pkg::CH_LF, 16'd0, 1'b0, 1'b1));
    add_row(sqf_pkg::CH_DQ, 1, 1'b1, one_result(sqf_pkg::CH_CLOSE, 16'd0, 1'b1, 1'b0));
    add_row(sqf_pkg::CH_SP, 3, 1'b0, '0);
    add_row(sqf_pkg::CH_CR, 1, 1'b0, '0);
    add_row(21'h62, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_SP, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_CR, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_LF, 1, 1'b1, one_result(sqf_pkg::CH_LF, 16'd0, 1'b0, 1'b0));
    add_row(sqf_pkg::CH_CR, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_SP, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_LF, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_DQ, 1, 1'b1, one_result(sqf_pkg::CH_OPEN, 16'd0, 1'b0, 1'b0));
    add_row(sqf_pkg::CH_CR, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_LF, 1, 1'b1, one_result(sqf_pkg::CH_LF, 16'd0, 1'b0, 1'b1));
    add_row(sqf_pkg::CH_SP, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_LF, 1, 1'b1, one_result(sqf_pkg::CH_LF, 16'd0, 1'b0, 1'b0));
    add_row(sqf_pkg::CH_DQ, 1, 1'b1, one_result(sqf_pkg::CH_OPEN, 16'd0, 1'b0, 1'b0));
    add_row(sqf_pkg::CH_CR, 1, 1'b0, '0);
    add_row(21'h78, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_CR, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_DQ, 1, 1'b0, '0);
    add_row(21'h1FFFFF, 1, 1'b1, one_result(21'h1FFFFF, 16'd0, 1'b0, 1'b0));
    add_row(21'h000000, 1, 1'b1, one_result(21'h000000, 16'd0, 1'b0, 1'b0));
    add_row(sqf_pkg::CH_CR, 1, 1'b0, '0);
    add_row(sqf_pkg::CH_CR, 1, 1'b1, one_result(sqf_pkg::CH_CR, 16'd0, 1'b0, 1'b0));
    add_row(sqf_pkg::CH_LF, 1, 1'b1, one_result(sqf_pkg::CH_LF, 16'd0, 1'b0, 1'b0));
    add_row(sqf_pkg::CH_SP, SPACE_RUN, 1'b0, '0);
    add_row(21'h71, 1, 1'b1, one_result(21'h71, 16'(SPACE_RUN), 1'b0, 1'b0));

    foreach (directed_rows[i]) begin
      steady = directed_rows[i].reps > 1;
      repeat (directed_rows[i].reps)
        send_code(directed_rows[i].cp, directed_rows[i].typed, directed_rows[i].res);
    end
    steady = 1'b0;

    for (int p = 0; p < 4; p++) begin
      settle_idle();
      write_mode(p[0] ? 1'b0 : 1'b1);
      if (p == 1) hold_off_req = 1'b1;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (k % 100 == 0) steady = $urandom_range(0, 3) == 0;
        if (char_script.size() == 0) add_snippet();
        send_code(char_script.pop_front(), 1'b0, '0);
      end
      steady = 1'b0;
    end

    settle_idle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
